### rtl/core/ute_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ute_pkg
// Shared types and constants for the unordered table engine.
// -----------------------------------------------------------------------------
package ute_pkg;

	localparam int VAL_W   = 32;
	localparam int POS_W   = 5;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 5;
	localparam int APB_AW  = 2;
	localparam int APB_DW  = 32;
	localparam int IN_DW   = 40;
	localparam int OUT_DW  = 48;

	localparam logic [CFG_W-1:0]  CAP_RESET   = 5'd16;
	localparam logic [APB_AW-1:0] REG_CAP_ADR = 2'd0;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

endpackage
`default_nettype wire

### rtl/core/ute_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ute_ram
// Generic single write, single read RAM with a registered read port.
// -----------------------------------------------------------------------------
module ute_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/unordered_table_engine_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// unordered_table_engine_unit
// Unordered table of signed 32-bit values with insert, search, remove, list.
// -----------------------------------------------------------------------------
// The table sits in one RAM with a single write and a single registered read
// port, so every operation is a short walk through that port and one item is
// worked on at a time. Insert at the end writes the value as the item is taken;
// insert inside the table reads the occupant, moves it to the end, then writes
// the new value. Search inspects the entries in order up to the hit; remove
// adds a write-back of the last entry into the hit slot, as the read of the
// last entry overlaps the cycle that finds the hit.
// List gives one result per cycle while the output is taken. Each result is
// registered in the output register; the next item is taken as soon as the
// engine is back in idle, even if that result still waits.
// No clearing pass is needed after reset.
// -----------------------------------------------------------------------------
module unordered_table_engine_unit
	import ute_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave side
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_DW-1:0]  s_tdata,  // [31:0] value, [36:32] position, zero pad
	input  wire logic [1:0]        s_tuser,  // [1:0] operation
	// master side
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DW-1:0]      m_tdata,  // [3:0] index, [35:4] element, [40:36] count
	output logic                   m_tuser,  // [0] success
	output logic                   m_tlast,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_INS_MV = 7'b0000100,
		ST_INS_WR = 7'b0001000,
		ST_REM_WR = 7'b0010000,
		ST_LIST   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [VAL_W-1:0]  val_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic [CFG_W-1:0]  cap_q;
	logic              res_ok_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic              m_valid_q;
	logic [OUT_DW-1:0] m_data_q;
	logic              m_user_q;
	logic              m_last_q;

	// ram port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	// decoded input item
	op_t               in_op;
	logic [VAL_W-1:0]  in_val;
	logic [XW-1:0]     in_pos_x;
	logic [AW-1:0]     in_pos;

	logic              s_fire;
	logic              out_load;
	logic              res_load;
	logic [XW-1:0]     count_x;
	logic [XW-1:0]     cap_x;
	logic [XW-1:0]     cap_eff;
	logic              ins_ok;
	logic              ins_append;
	logic              cnt_zero;
	logic              hit;
	logic              at_end;
	logic [IDX_W-1:0]  idx4;
	logic [XW-1:0]     idx_x;

	assign in_op    = op_t'(s_tuser);
	assign in_val   = s_tdata[VAL_W-1:0];
	assign in_pos_x = XW'(s_tdata[VAL_W +: POS_W]);
	assign in_pos   = in_pos_x[AW-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_load = !m_valid_q || m_tready;
	assign res_load = ((state_q == ST_LIST) || (state_q == ST_EMIT)) && out_load;

	assign count_x    = XW'(count_q);
	assign cap_x      = XW'(cap_q);
	assign cap_eff    = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
	assign ins_ok     = (count_x < cap_eff) && (in_pos_x <= count_x);
	assign ins_append = (in_pos_x == count_x);
	assign cnt_zero   = (count_q == '0);
	assign hit        = (ram_rdata == val_q);
	assign idx_x      = XW'(idx_q);
	assign at_end     = ((idx_x + XW'(1)) == count_x);
	assign idx4       = idx_x[IDX_W-1:0];

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = val_q;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (in_op == OP_INSERT) begin
						if (ins_ok && ins_append) begin
							ram_we    = 1'b1;
							ram_waddr = AW'(count_q);
							ram_wdata = in_val;
						end
						ram_raddr = in_pos;
					end else begin
						ram_raddr = '0;
					end
				end
			end
			ST_SCAN: begin
				if (hit && op_q == OP_REMOVE) begin
					ram_raddr = AW'(count_q - CW'(1));
				end else begin
					ram_raddr = idx_q + AW'(1);
				end
			end
			ST_INS_MV: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(count_q);
				ram_wdata = ram_rdata;
			end
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			ST_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
			ST_LIST: begin
				// hold the address while the output stalls so the read data stays put
				if (out_load && !at_end) begin
					ram_raddr = idx_q + AW'(1);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ute_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						case (in_op)
							OP_INSERT: begin
								if (!ins_ok) begin
									state_q <= ST_EMIT;
								end else if (ins_append) begin
									count_q <= count_q + CW'(1);
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_INS_MV;
								end
							end
							OP_SEARCH, OP_REMOVE: begin
								state_q <= cnt_zero ? ST_EMIT : ST_SCAN;
							end
							OP_LIST: begin
								state_q <= cnt_zero ? ST_EMIT : ST_LIST;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= (op_q == OP_REMOVE) ? ST_REM_WR : ST_EMIT;
					end else if (at_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_INS_MV: begin
					state_q <= ST_INS_WR;
				end
				ST_INS_WR: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_EMIT;
				end
				ST_REM_WR: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_EMIT;
				end
				ST_LIST: begin
					if (out_load && at_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					op_q      <= in_op;
					val_q     <= in_val;
					pos_q     <= in_pos;
					idx_q     <= '0;
					res_ok_q  <= (in_op == OP_INSERT) && ins_ok;
					res_idx_q <= '0;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					res_ok_q  <= 1'b1;
					res_idx_q <= idx4;
				end else if (!at_end) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			ST_LIST: begin
				if (out_load) begin
					m_user_q <= 1'b1;
					m_last_q <= at_end;
					m_data_q <= OUT_DW'({count_x[CNT_W-1:0], ram_rdata, idx4});
					idx_q    <= idx_q + AW'(1);
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					m_user_q <= res_ok_q;
					m_last_q <= 1'b1;
					m_data_q <= OUT_DW'({count_x[CNT_W-1:0], {VAL_W{1'b0}}, res_idx_q});
				end
			end
			default: begin
				res_ok_q <= res_ok_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_CAP_ADR) begin
			cap_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAP_ADR) ? APB_DW'(cap_q) : '0;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_x <= XW'(DEPTH))
		else $error("element count beyond storage depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
		else $error("element count moved by more than one");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_LIST) |-> idx_x < count_x)
		else $error("table walk beyond the element count");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST || state_q == ST_EMIT || state_q == ST_SCAN) |-> !ram_we)
		else $error("table written outside an update step");
`endif

endmodule
`default_nettype wire
